FILE: src/cas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_pkg
// shared constants, codes and controller/datapath handshake types
// ----------------------------------------------------------------------------
package cas_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned POS_W   = $clog2(CAPACITY_DEF);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned COUNT_W = $clog2(CAPACITY_DEF + 1);

  // request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ERASE  = 2'd2;

  // status codes
  localparam logic [STS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic             append;        // write value at tail, count up
    logic             read_pos;      // read entry at requested index
    logic             shift_start;   // pointer to index, read the next entry
    logic             shift_step;    // move one entry down, read the one after
    logic             cnt_dec;       // count down after an erase
    logic             stage;         // capture the result word
    logic [STS_W-1:0] stage_status;
    logic             stage_rdata;   // value from read data, else zero
    logic             out_load;      // move the result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;         // count at capacity
    logic in_range;     // requested index below count
    logic first_more;   // an entry follows the erased one
    logic shift_more;   // another entry still has to move
  } sts_t;

endpackage

FILE: src/cas_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_ctrl
// request sequencer: decodes a word, steps reads and erase shifts, hands off
// ----------------------------------------------------------------------------
module cas_ctrl
  import cas_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_DONE;
          unique case (req_type_i)
            REQ_APPEND: begin
              cmd_o.stage = 1'b1;
              if (sts_i.full) begin
                cmd_o.stage_status = STATUS_FULL;
              end else begin
                cmd_o.append       = 1'b1;
                cmd_o.stage_status = STATUS_OK;
              end
            end
            REQ_READ: begin
              if (sts_i.in_range) begin
                cmd_o.read_pos = 1'b1;
                state_d        = S_READ;
              end else begin
                cmd_o.stage        = 1'b1;
                cmd_o.stage_status = STATUS_RANGE;
              end
            end
            REQ_ERASE: begin
              if (!sts_i.in_range) begin
                cmd_o.stage        = 1'b1;
                cmd_o.stage_status = STATUS_RANGE;
              end else if (sts_i.first_more) begin
                cmd_o.shift_start = 1'b1;
                state_d           = S_SHIFT;
              end else begin
                cmd_o.cnt_dec      = 1'b1;
                cmd_o.stage        = 1'b1;
                cmd_o.stage_status = STATUS_OK;
              end
            end
            default: begin
              cmd_o.stage        = 1'b1;
              cmd_o.stage_status = STATUS_RANGE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.stage        = 1'b1;
        cmd_o.stage_status = STATUS_OK;
        cmd_o.stage_rdata  = 1'b1;
        state_d            = S_DONE;
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (!sts_i.shift_more) begin
          cmd_o.cnt_dec      = 1'b1;
          cmd_o.stage        = 1'b1;
          cmd_o.stage_status = STATUS_OK;
          state_d            = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_one_word_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new word taken while one is in flight");

  a_done_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> (state_q == S_DONE))
    else $error("result left done state while output was blocked");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("output load without valid");
`endif

endmodule

FILE: src/cas_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_dp
// entry memory, live count, erase pointer and result registers
// ----------------------------------------------------------------------------
module cas_dp
  import cas_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cmd_t                               cmd_i,
  output sts_t                               sts_o,
  input  logic [$clog2(CAPACITY)-1:0]        position_i,
  input  logic signed [DATA_W-1:0]           value_in_i,
  output logic signed [DATA_W-1:0]           read_value_o,
  output logic [STS_W-1:0]                   status_o,
  output logic [$clog2(CAPACITY + 1)-1:0]    item_count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((CW > AW) ? CW : AW) + 2;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_q;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] ptr_q, ptr_d;

  logic [STS_W-1:0]         stage_status_q;
  logic signed [DATA_W-1:0] stage_value_q;
  logic [STS_W-1:0]         out_status_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic [CW-1:0]            out_count_q;

  logic [XW-1:0]     pos_x, cnt_x, ptr_x;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data;

  assign pos_x = XW'(position_i);
  assign cnt_x = XW'(count_q);
  assign ptr_x = XW'(ptr_q);

  assign sts_o.full       = (count_q == CW'(CAPACITY));
  assign sts_o.in_range   = (pos_x < cnt_x);
  assign sts_o.first_more = ((pos_x + XW'(1)) < cnt_x);
  assign sts_o.shift_more = ((ptr_x + XW'(2)) < cnt_x);

  // one write port: tail append or one step of the erase shift
  assign wr_en   = cmd_i.append | cmd_i.shift_step;
  assign wr_addr = cmd_i.append ? AW'(count_q) : ptr_q;
  assign wr_data = cmd_i.append ? value_in_i : rdata_q;

  // one read port: requested entry, or the next entry to move down
  assign rd_en = cmd_i.read_pos | cmd_i.shift_start | (cmd_i.shift_step & sts_o.shift_more);

  always_comb begin
    priority if (cmd_i.read_pos) begin
      rd_addr = AW'(pos_x);
    end else if (cmd_i.shift_start) begin
      rd_addr = AW'(pos_x + XW'(1));
    end else begin
      rd_addr = AW'(ptr_x + XW'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.append) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.shift_start) begin
      ptr_d = AW'(pos_x);
    end else if (cmd_i.shift_step) begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.stage) begin
      stage_status_q <= cmd_i.stage_status;
      stage_value_q  <= cmd_i.stage_rdata ? rdata_q : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= stage_status_q;
      out_value_q  <= stage_value_q;
      out_count_q  <= count_q;
    end
  end

  assign read_value_o = out_value_q;
  assign status_o     = out_status_q;
  assign item_count_o = out_count_q;

`ifndef SYNTHESIS
  a_append_counts_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |=> (count_q == CW'($past(count_q) + CW'(1))))
    else $error("append did not raise the count");

  a_no_dec_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> (count_q != '0))
    else $error("erase on an empty list");
`endif

endmodule

FILE: src/compacting_array_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_array_store
// ordered list of signed 32-bit words in a fixed memory, with append, read
// at index and erase at index that closes the gap
// ----------------------------------------------------------------------------
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+------------------------------------
//  request | in_valid_i | in_ready_o  | req_type_i, position_i, value_in_i
//  result  | out_valid_o| out_ready_i | read_value_o, status_o, item_count_o
//
// one request word at a time; the result register loads in the cycle before
// the earliest next accept, and the steps from an accept are:
//   append, rejected or out-of-range word: decode, then load the result
//   read: decode, registered memory read, then load the result
//   erase at index p: start, then a shift step for each live entry after p,
//   then load; the single memory write port moves one entry per cycle
// the result register lets the next word in while a result waits downstream
// rst_ni clears the count and handshake state; memory contents are not reset
//
module compacting_array_store
  import cas_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request word
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [REQ_W-1:0]                req_type_i,
  input  logic [$clog2(CAPACITY)-1:0]     position_i,
  input  logic signed [DATA_W-1:0]        value_in_i,
  // result word
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [DATA_W-1:0]        read_value_o,
  output logic [STS_W-1:0]                status_o,
  output logic [$clog2(CAPACITY + 1)-1:0] item_count_o
);

  // command and status bundles between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: decodes the word and steps multi-cycle operations
  cas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: entry memory, count, erase pointer and result registers
  cas_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .position_i   (position_i),
    .value_in_i   (value_in_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .item_count_o (item_count_o)
  );

endmodule
